/* src/xxh64_stream_hash_top_defines.svh */
// Assertion macros for the xxh64 stream hash checker.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef XXH64_STREAM_HASH_TOP_DEFINES_SVH
`define XXH64_STREAM_HASH_TOP_DEFINES_SVH

// Check that ante implies cons on the next cycle, outside reset.
`define XXH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xxh64 check failed");

// Check that ante implies cons on the next cycle, reset included.
`define XXH_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("xxh64 check failed");

`endif

/* src/xxh_pkg.sv */
// Shared constants, types and helpers of the xxh64 stream hash.
// No dependencies.
package xxh_pkg;

   localparam int LENGTH_BITS_DEF = 64;

   localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
   localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] prod;
   } mul_rsp_type;

   // rotate left by a constant, 1..63
   function automatic logic [63:0] rol64(input logic [63:0] x, input int r);
      rol64 = (x << r) | (x >> (64 - r));
   endfunction

   // lane rotation used when merging the accumulators
   function automatic logic [63:0] merge_rot(input logic [63:0] x, input logic [1:0] lane);
      logic [63:0] res;
      case (lane)
         2'd0: res = rol64(x, 1);
         2'd1: res = rol64(x, 7);
         2'd2: res = rol64(x, 12);
         default: res = rol64(x, 18);
      endcase
      return res;
   endfunction

endpackage

/* src/xxh_mul.sv */
// Multi-cycle 64x64 multiplier, low 64 bits of the product.
// One 32x32 multiplier reused for three partial products; uses xxh_pkg.
module xxh_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  xxh_pkg::mul_req_type mul_req,
   output xxh_pkg::mul_rsp_type mul_rsp
);

   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] x, y;
   logic [63:0] prod;

   always_comb begin
      x    = (step_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      y    = (step_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
      prod = 64'(x) * 64'(y);

      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.a;
         b_in    = mul_req.b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // low product first, then the two cross terms shifted up
         if (step_ff == 2'd0) begin
            acc_in = prod;
         end else begin
            acc_in = acc_ff + {prod[31:0], 32'd0};
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = acc_ff;

endmodule

/* src/xxh64_stream_hash_top.sv */
// Top level of the xxh64 stream hash: sequencer, lane and stripe state.
// Uses xxh_pkg and xxh_mul.
//
//  channel | ports                                        | role
//  --------+----------------------------------------------+---------------------
//  req     | req_valid req_ready req_data_word ...        | message words in
//  rsp     | rsp_valid rsp_ready rsp_hash_value           | one hash per message
//  csr     | csr_wr_en csr_wr_data                        | seed register write
//
// A word that does not complete a stripe is buffered. A word that completes
// a stripe runs 8 multiplies, two per lane, on the shared multiplier (one
// 32x32 product per cycle, three per 64-bit multiply). The last word adds
// finalization: if a stripe was folded, the four lanes are summed and merged
// in four rounds; the length is added, one round runs per buffered word, then
// a 4-byte tail and each byte; emit stalls while the output is occupied.
// Reset is synchronous and clears the sequencer and message state; a finished
// hash waits in the output register while the next message is accepted.
module xxh64_stream_hash_top #(
   parameter int LENGTH_BITS = xxh_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   localparam int NS = 27;

   typedef enum logic [NS-1:0] {
      S_IDLE    = NS'(1) << 0,
      S_LR_M1   = NS'(1) << 1,
      S_LR_W1   = NS'(1) << 2,
      S_LR_M2   = NS'(1) << 3,
      S_LR_W2   = NS'(1) << 4,
      S_FIN     = NS'(1) << 5,
      S_MRG_ADD = NS'(1) << 6,
      S_RND_M1  = NS'(1) << 7,
      S_RND_W1  = NS'(1) << 8,
      S_RND_M2  = NS'(1) << 9,
      S_RND_W2  = NS'(1) << 10,
      S_RND_M3  = NS'(1) << 11,
      S_RND_W3  = NS'(1) << 12,
      S_ADD_LEN = NS'(1) << 13,
      S_TAIL4   = NS'(1) << 14,
      S_T4_W1   = NS'(1) << 15,
      S_T4_M2   = NS'(1) << 16,
      S_T4_W2   = NS'(1) << 17,
      S_BYTE    = NS'(1) << 18,
      S_BY_W1   = NS'(1) << 19,
      S_BY_M2   = NS'(1) << 20,
      S_BY_W2   = NS'(1) << 21,
      S_AV_M1   = NS'(1) << 22,
      S_AV_W1   = NS'(1) << 23,
      S_AV_M2   = NS'(1) << 24,
      S_AV_W2   = NS'(1) << 25,
      S_EMIT    = NS'(1) << 26
   } state_type;

   state_type              state_ff, state_in;
   logic [63:0]            lane_ff [4];
   logic [63:0]            lane_in [4];
   logic [63:0]            buf_ff [4];
   logic [63:0]            buf_in [4];
   logic [1:0]             fill_ff, fill_in;
   logic                   done_ff, done_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [63:0]            seed_ff, seed_in;
   logic [63:0]            h_ff, h_in, t_ff, t_in, part_ff, part_in;
   logic [3:0]             nbytes_ff, nbytes_in, idx_ff, idx_in;
   logic                   last_ff, last_in, mrg_ff, mrg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            rsp_hash_ff, rsp_hash_in;

   xxh_pkg::mul_req_type   mul_req;
   xxh_pkg::mul_rsp_type   mul_rsp;

   logic [3:0]             ncl;
   logic                   push;
   logic [1:0]             li;

   xxh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign li = idx_ff[1:0];

   always_comb begin
      ncl  = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      push = !req_last_word || (ncl == 4'd8);

      state_in     = state_ff;
      lane_in      = lane_ff;
      buf_in       = buf_ff;
      fill_in      = fill_ff;
      done_in      = done_ff;
      len_in       = len_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      h_in         = h_ff;
      t_in         = t_ff;
      part_in      = part_ff;
      nbytes_in    = nbytes_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      mrg_in       = mrg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      mul_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               len_in    = len_ff + (req_last_word ? LENGTH_BITS'(ncl) : LENGTH_BITS'(8));
               last_in   = req_last_word;
               part_in   = req_data_word;
               nbytes_in = push ? 4'd0 : ncl;
               if (push) begin
                  buf_in[fill_ff] = req_data_word;
                  if (fill_ff == 2'd3) begin
                     if (!done_ff) begin
                        lane_in[0] = seed_ff + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
                        lane_in[1] = seed_ff + xxh_pkg::PRIME2;
                        lane_in[2] = seed_ff;
                        lane_in[3] = seed_ff - xxh_pkg::PRIME1;
                        done_in    = 1'b1;
                     end
                     idx_in   = 4'd0;
                     state_in = S_LR_M1;
                  end else begin
                     fill_in  = fill_ff + 2'd1;
                     state_in = req_last_word ? S_FIN : S_IDLE;
                  end
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_LR_M1: begin
            mul_req  = '{start: 1'b1, a: buf_ff[li], b: xxh_pkg::PRIME2};
            state_in = S_LR_W1;
         end
         S_LR_W1: begin
            if (mul_rsp.done) begin
               lane_in[li] = xxh_pkg::rol64(lane_ff[li] + mul_rsp.prod, 31);
               state_in    = S_LR_M2;
            end
         end
         S_LR_M2: begin
            mul_req  = '{start: 1'b1, a: lane_ff[li], b: xxh_pkg::PRIME1};
            state_in = S_LR_W2;
         end
         S_LR_W2: begin
            if (mul_rsp.done) begin
               lane_in[li] = mul_rsp.prod;
               if (li == 2'd3) begin
                  fill_in  = 2'd0;
                  state_in = last_ff ? S_FIN : S_IDLE;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_LR_M1;
               end
            end
         end
         S_FIN: begin
            idx_in = 4'd0;
            if (done_ff) begin
               h_in     = 64'd0;
               state_in = S_MRG_ADD;
            end else begin
               h_in     = seed_ff + xxh_pkg::PRIME5;
               state_in = S_ADD_LEN;
            end
         end
         S_MRG_ADD: begin
            h_in = h_ff + xxh_pkg::merge_rot(lane_ff[li], li);
            if (li == 2'd3) begin
               idx_in   = 4'd0;
               mrg_in   = 1'b1;
               state_in = S_RND_M1;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         S_RND_M1: begin
            mul_req  = '{start: 1'b1, a: (mrg_ff ? lane_ff[li] : buf_ff[li]),
                         b: xxh_pkg::PRIME2};
            state_in = S_RND_W1;
         end
         S_RND_W1: begin
            if (mul_rsp.done) begin
               t_in     = xxh_pkg::rol64(mul_rsp.prod, 31);
               state_in = S_RND_M2;
            end
         end
         S_RND_M2: begin
            mul_req  = '{start: 1'b1, a: t_ff, b: xxh_pkg::PRIME1};
            state_in = S_RND_W2;
         end
         S_RND_W2: begin
            if (mul_rsp.done) begin
               h_in     = h_ff ^ mul_rsp.prod;
               state_in = S_RND_M3;
            end
         end
         S_RND_M3: begin
            mul_req  = '{start: 1'b1, a: (mrg_ff ? h_ff : xxh_pkg::rol64(h_ff, 27)),
                         b: xxh_pkg::PRIME1};
            state_in = S_RND_W3;
         end
         S_RND_W3: begin
            if (mul_rsp.done) begin
               h_in = mul_rsp.prod + xxh_pkg::PRIME4;
               if (mrg_ff) begin
                  if (li == 2'd3) begin
                     state_in = S_ADD_LEN;
                  end else begin
                     idx_in   = idx_ff + 4'd1;
                     state_in = S_RND_M1;
                  end
               end else if ((idx_ff + 4'd1) == {2'b00, fill_ff}) begin
                  state_in = S_TAIL4;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_RND_M1;
               end
            end
         end
         S_ADD_LEN: begin
            h_in     = h_ff + 64'(len_ff);
            idx_in   = 4'd0;
            mrg_in   = 1'b0;
            state_in = (fill_ff != 2'd0) ? S_RND_M1 : S_TAIL4;
         end
         S_TAIL4: begin
            if (nbytes_ff >= 4'd4) begin
               mul_req  = '{start: 1'b1, a: {32'd0, part_ff[31:0]}, b: xxh_pkg::PRIME1};
               state_in = S_T4_W1;
            end else begin
               idx_in   = 4'd0;
               state_in = S_BYTE;
            end
         end
         S_T4_W1: begin
            if (mul_rsp.done) begin
               h_in     = h_ff ^ mul_rsp.prod;
               state_in = S_T4_M2;
            end
         end
         S_T4_M2: begin
            mul_req  = '{start: 1'b1, a: xxh_pkg::rol64(h_ff, 23), b: xxh_pkg::PRIME2};
            state_in = S_T4_W2;
         end
         S_T4_W2: begin
            if (mul_rsp.done) begin
               h_in     = mul_rsp.prod + xxh_pkg::PRIME3;
               idx_in   = 4'd4;
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (idx_ff < nbytes_ff) begin
               mul_req  = '{start: 1'b1, a: {56'd0, part_ff[idx_ff[2:0]*8 +: 8]},
                            b: xxh_pkg::PRIME5};
               state_in = S_BY_W1;
            end else begin
               state_in = S_AV_M1;
            end
         end
         S_BY_W1: begin
            if (mul_rsp.done) begin
               h_in     = h_ff ^ mul_rsp.prod;
               state_in = S_BY_M2;
            end
         end
         S_BY_M2: begin
            mul_req  = '{start: 1'b1, a: xxh_pkg::rol64(h_ff, 11), b: xxh_pkg::PRIME1};
            state_in = S_BY_W2;
         end
         S_BY_W2: begin
            if (mul_rsp.done) begin
               h_in     = mul_rsp.prod;
               idx_in   = idx_ff + 4'd1;
               state_in = S_BYTE;
            end
         end
         S_AV_M1: begin
            mul_req  = '{start: 1'b1, a: h_ff ^ (h_ff >> 33), b: xxh_pkg::PRIME2};
            state_in = S_AV_W1;
         end
         S_AV_W1: begin
            if (mul_rsp.done) begin
               h_in     = mul_rsp.prod;
               state_in = S_AV_M2;
            end
         end
         S_AV_M2: begin
            mul_req  = '{start: 1'b1, a: h_ff ^ (h_ff >> 29), b: xxh_pkg::PRIME3};
            state_in = S_AV_W2;
         end
         S_AV_W2: begin
            if (mul_rsp.done) begin
               h_in     = mul_rsp.prod ^ (mul_rsp.prod >> 32);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register is free, then drop message state
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = h_ff;
               fill_in      = 2'd0;
               done_in      = 1'b0;
               len_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= 2'd0;
         done_ff      <= 1'b0;
         len_ff       <= '0;
         seed_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         done_ff      <= done_in;
         len_ff       <= len_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lane_ff     <= lane_in;
      buf_ff      <= buf_in;
      h_ff        <= h_in;
      t_ff        <= t_in;
      part_ff     <= part_in;
      nbytes_ff   <= nbytes_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      mrg_ff      <= mrg_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

/* src/xxh_checker.sv */
// Port-level checker for the xxh64 stream hash, bound to the top level.
// Uses the assertion macros of xxh64_stream_hash_top_defines.svh.
`include "xxh64_stream_hash_top_defines.svh"

module xxh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_value
);

   `XXH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `XXH_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_hash_value))
   `XXH_ASSERT_NEXT(a_last_busy, req_valid && req_ready && req_last_word, !req_ready)
   `XXH_ASSERT_NEXT(a_no_rsp_on_accept, req_valid && req_ready, !$rose(rsp_valid))
   `XXH_ASSERT_ALWAYS(a_reset_clear, reset, !rsp_valid && req_ready)

endmodule

bind xxh64_stream_hash_top xxh_checker u_xxh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last_word  (req_last_word),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);
